// ----- hdl/multi_phrase_text_matcher_assert.svh -----
// Assertion macros shared by the matcher modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MULTI_PHRASE_TEXT_MATCHER_ASSERT_SVH
`define MULTI_PHRASE_TEXT_MATCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mptm_pkg.sv -----
// ----------------------------------------------------------------------------
// mptm_pkg
// Types, constants and the phrase table of the multi-phrase text matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mptm_pkg;

  localparam int PHRASE_COUNT   = 15;
  localparam int ROM_SLOTS      = 16;
  localparam int MAX_PHRASE_LEN = 32;
  localparam int HIST_DEPTH     = MAX_PHRASE_LEN - 1;
  localparam int OFFSET_BITS    = 16;
  localparam int RES_SLOTS      = 3;

  localparam int ID_W   = $clog2(ROM_SLOTS);
  localparam int LEN_W  = $clog2(MAX_PHRASE_LEN + 1);
  localparam int DIST_W = $clog2(MAX_PHRASE_LEN);
  localparam int TXT_W  = 8 * MAX_PHRASE_LEN;
  localparam int CNT_W  = $clog2(RES_SLOTS + 1);
  localparam int IDX_W  = $clog2(RES_SLOTS);

  localparam logic [6:0] CONFIDENCE = 7'd95;

  // Register map (word index).
  localparam logic REG_RESULT_LIMIT = 1'b0;
  localparam logic [15:0] RESULT_LIMIT_RESET = 16'd16;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic        is_summary;
    logic [15:0] match_offset;
    logic [5:0]  match_length;
    logic [3:0]  phrase_id;
    logic [6:0]  confidence;
    logic [15:0] match_total;
    logic        last_result;
  } out_t;

  // All results caused by one accepted byte, in delivery order.
  typedef struct packed {
    out_t [RES_SLOTS-1:0] res;
    logic [CNT_W-1:0]     count;
  } bundle_t;

  // Phrase text, right aligned: the last character sits in bits [7:0].
  function automatic logic [TXT_W-1:0] phrase_text(input logic [ID_W-1:0] id);
    logic [TXT_W-1:0] t;
    t = '0;
    case (id)
      4'd0:    t = "he said";
      4'd1:    t = "she said";
      4'd2:    t = "she told";
      4'd3:    t = "he told";
      4'd4:    t = "i heard";
      4'd5:    t = "according to";
      4'd6:    t = "reportedly";
      4'd7:    t = "allegedly";
      4'd8:    t = "it was reported";
      4'd9:    t = "sources say";
      4'd10:   t = "witnesses claim";
      4'd11:   t = "testimony indicates";
      4'd12:   t = "didn't you say";
      4'd13:   t = "you mentioned";
      4'd14:   t = "as stated by";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [LEN_W-1:0] phrase_len(input logic [ID_W-1:0] id);
    logic [LEN_W-1:0] n;
    n = '0;
    case (id)
      4'd0:    n = 6'd7;
      4'd1:    n = 6'd8;
      4'd2:    n = 6'd8;
      4'd3:    n = 6'd7;
      4'd4:    n = 6'd7;
      4'd5:    n = 6'd12;
      4'd6:    n = 6'd10;
      4'd7:    n = 6'd9;
      4'd8:    n = 6'd15;
      4'd9:    n = 6'd11;
      4'd10:   n = 6'd15;
      4'd11:   n = 6'd19;
      4'd12:   n = 6'd14;
      4'd13:   n = 6'd13;
      4'd14:   n = 6'd12;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/multi_phrase_text_matcher.sv -----
// ----------------------------------------------------------------------------
// multi_phrase_text_matcher
// Case-insensitive search of a byte stream for a fixed set of phrases.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters one byte per beat on the in_ channel; end_of_text marks the
//   last byte of a text. Every phrase that ends at a byte gives a match beat
//   on the out_ channel (at most two per byte, lowest phrase id first), until
//   result_limit matches have been reported for the text. The last byte of a
//   text adds a summary beat with the number of matches reported, and the
//   window, position and count start over. last_result marks the final beat
//   caused by a byte.
//   The results of a byte are registered in the result buffer and then in the
//   output register. A byte is taken every cycle as long as each byte gives
//   at most one result and out_ready stays high; a byte with more results
//   holds in_ready low while they leave the single result port one by one.
//   When out_ready is low, the output register keeps its beat and one more
//   byte's results wait in the result buffer, then in_ready drops.
//   Reset clears the window, position and count and sets result_limit to 16.
//   result_limit is written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_phrase_text_matcher_assert.svh"

module multi_phrase_text_matcher (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mptm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mptm_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int RS = mptm_pkg::ROM_SLOTS;
  localparam int HD = mptm_pkg::HIST_DEPTH;

  logic [15:0]                      limit_r;
  logic [15:0]                      count_r;
  logic [15:0]                      count_nxt;
  logic [mptm_pkg::OFFSET_BITS-1:0] pos_r;
  logic [mptm_pkg::OFFSET_BITS-1:0] pos_nxt;

  logic                             in_fire;
  logic                             eot;
  logic [7:0]                       cur;
  logic                             shift;
  logic                             clear;

  logic [7:0]                       cell_byte [HD+1];
  logic                             cell_valid [HD+1];
  logic [RS-1:0]                    cell_hit [HD];
  logic [RS-1:0]                    match;
  logic [RS-1:0]                    match_rest;
  logic [mptm_pkg::ID_W-1:0]        id_a;
  logic [mptm_pkg::ID_W-1:0]        id_b;
  logic [1:0]                       n_found;
  logic [1:0]                       n_match;
  logic [mptm_pkg::CNT_W-1:0]       n_res;
  logic                             room1;
  logic                             room2;

  mptm_pkg::out_t                   res_a;
  mptm_pkg::out_t                   res_b;
  mptm_pkg::out_t                   res_sum;
  mptm_pkg::bundle_t                bundle;
  logic                             buf_ready;

  function automatic logic [mptm_pkg::ID_W-1:0] lowest_set(input logic [RS-1:0] v);
    logic [mptm_pkg::ID_W-1:0] r;
    r = '0;
    for (int i = RS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = mptm_pkg::ID_W'(i);
      end
    end
    return r;
  endfunction

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mptm_pkg::REG_RESULT_LIMIT);
  assign prdata = (paddr[2] == mptm_pkg::REG_RESULT_LIMIT) ? {16'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mptm_pkg::RESULT_LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[15:0];
    end
  end

  assign in_ready = buf_ready;
  assign in_fire  = in_valid && in_ready;
  assign eot      = in_data.end_of_text;
  assign cur      = mptm_pkg::fold_case(in_data.text_byte);
  assign shift    = in_fire && !eot;
  assign clear    = in_fire && eot;

  // History window: cell k holds the byte k+1 positions before the current one.
  assign cell_byte[0]  = cur;
  assign cell_valid[0] = 1'b1;

  for (genvar k = 0; k < HD; k++) begin : g_cell
    mptm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (shift),
      .clear_i (clear),
      .dist_i  (mptm_pkg::DIST_W'(k + 1)),
      .byte_i  (cell_byte[k]),
      .valid_i (cell_valid[k]),
      .byte_o  (cell_byte[k+1]),
      .valid_o (cell_valid[k+1]),
      .hit_o   (cell_hit[k])
    );
  end

  always_comb begin
    logic [mptm_pkg::TXT_W-1:0] txt;
    for (int p = 0; p < RS; p++) begin
      txt = mptm_pkg::phrase_text(mptm_pkg::ID_W'(p));
      match[p] = (p < mptm_pkg::PHRASE_COUNT)
              && (mptm_pkg::phrase_len(mptm_pkg::ID_W'(p)) != '0)
              && (cur == txt[7:0]);
    end
    for (int k = 0; k < HD; k++) begin
      match = match & cell_hit[k];
    end
  end

  // The first two phrases that end here, cut down to what the limit leaves.
  assign id_a       = lowest_set(match);
  assign match_rest = match & ~(RS'(1) << id_a);
  assign id_b       = lowest_set(match_rest);
  assign n_found    = {1'b0, match != '0} + {1'b0, match_rest != '0};
  assign room1      = count_r < limit_r;
  assign room2      = ({1'b0, count_r} + 17'd1) < {1'b0, limit_r};
  assign n_match    = !room1 ? 2'd0 : (!room2 && n_found != 2'd0) ? 2'd1 : n_found;
  assign n_res      = mptm_pkg::CNT_W'(n_match) + mptm_pkg::CNT_W'(eot);
  assign count_nxt  = count_r + 16'(n_match);
  assign pos_nxt    = pos_r + 1'b1;

  always_comb begin
    res_a = '0;
    res_a.match_offset = 16'(pos_r + 1'b1 - mptm_pkg::OFFSET_BITS'(mptm_pkg::phrase_len(id_a)));
    res_a.match_length = mptm_pkg::phrase_len(id_a);
    res_a.phrase_id    = id_a;
    res_a.confidence   = mptm_pkg::CONFIDENCE;

    res_b = '0;
    res_b.match_offset = 16'(pos_r + 1'b1 - mptm_pkg::OFFSET_BITS'(mptm_pkg::phrase_len(id_b)));
    res_b.match_length = mptm_pkg::phrase_len(id_b);
    res_b.phrase_id    = id_b;
    res_b.confidence   = mptm_pkg::CONFIDENCE;

    res_sum = '0;
    res_sum.is_summary  = 1'b1;
    res_sum.match_total = count_nxt;

    bundle        = '0;
    bundle.count  = n_res;
    bundle.res[0] = (n_match != 2'd0) ? res_a : res_sum;
    bundle.res[1] = (n_match == 2'd2) ? res_b : res_sum;
    bundle.res[2] = res_sum;
    case (n_res)
      2'd1:    bundle.res[0].last_result = 1'b1;
      2'd2:    bundle.res[1].last_result = 1'b1;
      2'd3:    bundle.res[2].last_result = 1'b1;
      default: bundle.count = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pos_r   <= '0;
    end else if (in_fire) begin
      if (eot) begin
        count_r <= '0;
        pos_r   <= '0;
      end else begin
        count_r <= count_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  mptm_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (in_fire && (n_res != '0)),
    .bundle_i  (bundle),
    .ready_o   (buf_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `MPTM_ASSERT_NEXT(a_count_idle, !in_fire, $stable(count_r), "count moved without a beat")
  `MPTM_ASSERT_NOW(a_match_order, in_fire && n_match == 2'd2, id_a < id_b, "matches out of order")
  `MPTM_ASSERT_NEXT(a_eot_clears, in_fire && eot, count_r == 16'd0 && pos_r == '0, "text state kept")

endmodule

`default_nettype wire

// ----- hdl/mptm_cell.sv -----
// ----------------------------------------------------------------------------
// mptm_cell
// One history byte of the text window and its compare against every phrase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mptm_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            shift_i,
  input  wire logic                            clear_i,
  input  wire logic [mptm_pkg::DIST_W-1:0]     dist_i,
  input  wire logic [7:0]                      byte_i,
  input  wire logic                            valid_i,
  output logic [7:0]                           byte_o,
  output logic                                 valid_o,
  output logic [mptm_pkg::ROM_SLOTS-1:0]       hit_o
);

  logic [7:0] byte_r;
  logic       valid_r;

  always_ff @(posedge clk) begin
    if (shift_i) begin
      byte_r <= byte_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear_i) begin
      valid_r <= 1'b0;
    end else if (shift_i) begin
      valid_r <= valid_i;
    end
  end

  assign byte_o  = byte_r;
  assign valid_o = valid_r;

  // A phrase no longer than this cell's distance places no constraint on it.
  always_comb begin
    logic [mptm_pkg::TXT_W-1:0] txt;
    logic                       need;
    hit_o = '0;
    for (int p = 0; p < mptm_pkg::ROM_SLOTS; p++) begin
      txt  = mptm_pkg::phrase_text(mptm_pkg::ID_W'(p));
      need = {1'b0, dist_i} < mptm_pkg::phrase_len(mptm_pkg::ID_W'(p));
      hit_o[p] = !need || (valid_r && (byte_r == txt[8*dist_i +: 8]));
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mptm_result_buf.sv -----
// ----------------------------------------------------------------------------
// mptm_result_buf
// Holds the results of one byte and hands them out one beat at a time
// through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multi_phrase_text_matcher_assert.svh"

module mptm_result_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_i,
  input  wire mptm_pkg::bundle_t bundle_i,
  output logic                   ready_o,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mptm_pkg::out_t         out_data
);

  mptm_pkg::bundle_t             q_r;
  logic                          b_valid_r;
  logic [mptm_pkg::IDX_W-1:0]    idx_r;
  mptm_pkg::out_t                out_r;
  logic                          out_valid_r;

  logic take;
  logic last;

  assign take    = b_valid_r && (!out_valid_r || out_ready);
  assign last    = idx_r == mptm_pkg::IDX_W'(q_r.count - 1'b1);
  assign ready_o = !b_valid_r || (take && last);

  always_ff @(posedge clk) begin
    if (load_i) begin
      q_r <= bundle_i;
    end
    if (take) begin
      out_r <= q_r.res[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_i) begin
        b_valid_r <= 1'b1;
        idx_r     <= '0;
      end else if (take) begin
        if (last) begin
          b_valid_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MPTM_ASSERT_NOW(a_load_when_ready, load_i, ready_o, "bundle loaded while buffer busy")
  `MPTM_ASSERT_NOW(a_idx_in_range, b_valid_r, ({1'b0, idx_r} < q_r.count), "read index past bundle")
  `MPTM_ASSERT_NEXT(a_hold_rest, take && !last && !load_i, b_valid_r, "bundle dropped early")

endmodule

`default_nettype wire
